FILE: hw/rtl/gradient_fill_pixel_generator_core_macros.svh
// Assertion macros shared by the gradient fill RTL.
// Users must provide clk and arst_n in scope.
`ifndef GRADIENT_FILL_PIXEL_GENERATOR_CORE_MACROS_SVH
`define GRADIENT_FILL_PIXEL_GENERATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define GFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gfp assertion failed");

// Next-cycle implication, disabled in reset.
`define GFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gfp assertion failed");

`endif

FILE: hw/rtl/gfp_pkg.sv
// Shared types and constants for the gradient fill pixel generator.
// No dependencies.
package gfp_pkg;
	localparam int FRAC_BITS = 16;
	localparam int MAX_SIDE  = 4096;
	localparam int COORD_W   = 12;
	localparam int SIDE_W    = 13;
	localparam int Q_W       = 2 * FRAC_BITS;
	localparam int D_W       = 26;
	localparam int R_W       = D_W + 1;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int ROOT_W    = FRAC_BITS;
	localparam int REM_W     = FRAC_BITS + 1;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

	localparam logic [1:0] MODE_VERT  = 2'd0;
	localparam logic [1:0] MODE_HORZ  = 2'd1;
	localparam logic [1:0] MODE_RAD   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd6;

	// how t is finally chosen
	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_LIN  = 2'd1;
	localparam logic [1:0] SEL_RAD  = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
	} pix_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		logic [1:0]          sel;
		logic                sat;
		logic [FRAC_BITS-1:0] tlin;
	} tag_t;
endpackage

FILE: hw/rtl/gfp_div_cell.sv
// One restoring-division step: one quotient bit per cell.
// Depends on gfp_pkg.
module gfp_div_cell import gfp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_i,
	input  logic [R_W-1:0] r_i,
	input  logic [D_W-1:0] d_i,
	input  logic [Q_W-1:0] q_i,
	input  tag_t           tag_i,
	output logic           v_o,
	output logic [R_W-1:0] r_o,
	output logic [D_W-1:0] d_o,
	output logic [Q_W-1:0] q_o,
	output tag_t           tag_o
);
	logic [R_W-1:0] r2;
	logic           ge;

	assign r2 = {r_i[R_W-2:0], 1'b0};
	assign ge = r2 >= {1'b0, d_i};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o <= 1'b0;
		else if (en) v_o <= v_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_o   <= ge ? (r2 - {1'b0, d_i}) : r2;
			d_o   <= d_i;
			q_o   <= {q_i[Q_W-2:0], ge};
			tag_o <= tag_i;
		end
	end
endmodule

FILE: hw/rtl/gfp_sqrt_cell.sv
// One digit-by-digit square root step: one root bit per cell.
// Depends on gfp_pkg.
module gfp_sqrt_cell import gfp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              v_i,
	input  logic [Q_W-1:0]    x_i,
	input  logic [REM_W-1:0]  rem_i,
	input  logic [ROOT_W-1:0] root_i,
	input  tag_t              tag_i,
	output logic              v_o,
	output logic [Q_W-1:0]    x_o,
	output logic [REM_W-1:0]  rem_o,
	output logic [ROOT_W-1:0] root_o,
	output tag_t              tag_o
);
	logic [REM_W+1:0] acc;
	logic [REM_W+1:0] trial;
	logic             ge;

	assign acc   = {rem_i, x_i[Q_W-1:Q_W-2]};
	assign trial = {1'b0, root_i, 2'b01};
	assign ge    = acc >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o <= 1'b0;
		else if (en) v_o <= v_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_o    <= {x_i[Q_W-3:0], 2'b00};
			rem_o  <= ge ? REM_W'(acc - trial) : REM_W'(acc);
			root_o <= {root_i[ROOT_W-2:0], ge};
			tag_o  <= tag_i;
		end
	end
endmodule

FILE: hw/rtl/gfp_blend.sv
// Channel blend: start*(1-t) + end*t per byte, products registered.
// Depends on gfp_pkg.
module gfp_blend import gfp_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           v_i,
	input  logic [T_W-1:0] t_i,
	input  logic [31:0]    c1,
	input  logic [31:0]    c2,
	output logic           v_o,
	output rgba_t          px_o
);
	localparam int P_W = T_W + 8;
	logic [P_W-1:0] pa_s1 [4];
	logic [P_W-1:0] pb_s1 [4];
	logic [T_W-1:0] tinv;
	logic [7:0]     ch [4];

	assign tinv = T_ONE - t_i;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_o <= 1'b0;
		else if (en) v_o <= v_i;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				pa_s1[k] <= P_W'(c1[8*k +: 8]) * P_W'(tinv);
				pb_s1[k] <= P_W'(c2[8*k +: 8]) * P_W'(t_i);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ch[k] = 8'((pa_s1[k] + pb_s1[k]) >> FRAC_BITS);
		end
	end

	assign px_o = '{red: ch[0], green: ch[1], blue: ch[2], alpha: ch[3]};
endmodule

FILE: hw/rtl/gradient_fill_pixel_generator_core.sv
// Gradient fill pixel generator: one pixel coordinate in, one RGBA color out.
// Pipeline: 3 setup stages, 32 divide cells, 16 root cells, t stage, blend
// product stage and output register. Throughput: one pixel per clock;
// the whole pipeline holds only when the output register is full and stalled.
// Reset: config goes to mode vertical, 1x1 area, center 0, colors 0; pipeline
// valids clear. Depends on gfp_pkg, the cells, gfp_blend and the macros header.
`include "gradient_fill_pixel_generator_core_macros.svh"
module gradient_fill_pixel_generator_core import gfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_t                 pix,
	output logic                 rgba_valid,
	input  logic                 rgba_stall,
	output rgba_t                rgba
);
	localparam int NDIV  = Q_W;
	localparam int NSQRT = ROOT_W;

	// configuration registers
	logic [1:0]         mode_q;
	logic [SIDE_W-1:0]  width_q, height_q;
	logic [COORD_W-1:0] cx_q, cy_q;
	logic [31:0]        start_q, end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_VERT;
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
			cx_q     <= '0;
			cy_q     <= '0;
			start_q  <= '0;
			end_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data[SIDE_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[SIDE_W-1:0];
				REG_CX:     cx_q     <= cfg_data[COORD_W-1:0];
				REG_CY:     cy_q     <= cfg_data[COORD_W-1:0];
				REG_START:  start_q  <= cfg_data;
				REG_END:    end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: hold everything while a finished pixel waits
	logic en;
	logic out_valid_q;
	assign en        = !out_valid_q || !rgba_stall;
	assign pix_stall = !en;

	// stage 1: clamp sides, pick center, distances
	logic [SIDE_W-1:0]  w_c, h_c;
	logic [COORD_W-1:0] cx_c, cy_c;
	logic [COORD_W:0]   dx_c, dy_c;
	logic [1:0]         sel_c;

	always_comb begin
		w_c = (width_q == '0) ? SIDE_W'(1) :
		      (width_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : width_q;
		h_c = (height_q == '0) ? SIDE_W'(1) :
		      (height_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : height_q;
		if (cx_q == '0 && cy_q == '0) begin
			cx_c = COORD_W'(w_c >> 1);
			cy_c = COORD_W'(h_c >> 1);
		end else begin
			cx_c = cx_q;
			cy_c = cy_q;
		end
		dx_c = {1'b0, pix.pixel_x} - {1'b0, cx_c};
		dy_c = {1'b0, pix.pixel_y} - {1'b0, cy_c};
		case (mode_q)
			MODE_VERT: sel_c = SEL_LIN;
			MODE_HORZ: sel_c = SEL_LIN;
			MODE_RAD:  sel_c = SEL_RAD;
			default:   sel_c = SEL_ZERO;
		endcase
	end

	logic               v_s1;
	logic [1:0]         sel_s1;
	logic [COORD_W-1:0] pos_s1, adx_s1, ady_s1;
	logic [SIDE_W-1:0]  len_s1, w_s1, h_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= pix_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s1 <= sel_c;
			pos_s1 <= (mode_q == MODE_HORZ) ? pix.pixel_x : pix.pixel_y;
			len_s1 <= (mode_q == MODE_HORZ) ? w_c : h_c;
			adx_s1 <= dx_c[COORD_W] ? COORD_W'(-dx_c) : dx_c[COORD_W-1:0];
			ady_s1 <= dy_c[COORD_W] ? COORD_W'(-dy_c) : dy_c[COORD_W-1:0];
			w_s1   <= w_c;
			h_s1   <= h_c;
		end
	end

	// stage 2: squares
	logic               v_s2;
	logic [1:0]         sel_s2;
	logic [COORD_W-1:0] pos_s2;
	logic [SIDE_W-1:0]  len_s2;
	logic [2*COORD_W-1:0] dxx_s2, dyy_s2;
	logic [D_W-1:0]     ww_s2, hh_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sel_s2 <= sel_s1;
			pos_s2 <= pos_s1;
			len_s2 <= len_s1;
			dxx_s2 <= adx_s1 * adx_s1;
			dyy_s2 <= ady_s1 * ady_s1;
			ww_s2  <= D_W'(w_s1) * D_W'(w_s1);
			hh_s2  <= D_W'(h_s1) * D_W'(h_s1);
		end
	end

	// stage 3: sums, saturation test, divider operands
	logic [R_W-1:0] d4_c;
	logic [D_W-1:0] s_c;
	logic           sat_c;

	always_comb begin
		d4_c = {R_W'(dxx_s2) + R_W'(dyy_s2)} << 2;
		s_c  = ww_s2 + hh_s2;
		case (sel_s2)
			SEL_LIN: sat_c = {1'b0, pos_s2} >= len_s2;
			SEL_RAD: sat_c = d4_c >= {1'b0, s_c};
			default: sat_c = 1'b0;
		endcase
	end

	logic           v_s3;
	logic [R_W-1:0] n_s3;
	logic [D_W-1:0] dv_s3;
	tag_t           tag_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	// keep the running remainder below the divisor: zero it when saturated or when sel is zero
	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_c || sel_s2 == SEL_ZERO) begin
				n_s3  <= '0;
				dv_s3 <= D_W'(1);
			end else if (sel_s2 == SEL_LIN) begin
				n_s3  <= R_W'(pos_s2);
				dv_s3 <= D_W'(len_s2);
			end else begin
				n_s3  <= d4_c;
				dv_s3 <= s_c;
			end
			tag_s3 <= '{sel: sel_s2, sat: sat_c, tlin: '0};
		end
	end

	// divider chain: one quotient bit per cell, 2*FRAC_BITS bits
	logic           dv  [NDIV+1];
	logic [R_W-1:0] dr  [NDIV+1];
	logic [D_W-1:0] dd  [NDIV+1];
	logic [Q_W-1:0] dq  [NDIV+1];
	tag_t           dt  [NDIV+1];

	assign dv[0] = v_s3;
	assign dr[0] = n_s3;
	assign dd[0] = dv_s3;
	assign dq[0] = '0;
	assign dt[0] = tag_s3;

	for (genvar i = 0; i < NDIV; i++) begin : g_div
		gfp_div_cell u_cell (
			.clk, .arst_n, .en,
			.v_i(dv[i]), .r_i(dr[i]), .d_i(dd[i]), .q_i(dq[i]), .tag_i(dt[i]),
			.v_o(dv[i+1]), .r_o(dr[i+1]), .d_o(dd[i+1]), .q_o(dq[i+1]), .tag_o(dt[i+1])
		);
	end

	// root chain: linear t is the top half of the quotient, carried in the tag
	logic              sv  [NSQRT+1];
	logic [Q_W-1:0]    sx  [NSQRT+1];
	logic [REM_W-1:0]  srm [NSQRT+1];
	logic [ROOT_W-1:0] srt [NSQRT+1];
	tag_t              st  [NSQRT+1];

	assign sv[0]  = dv[NDIV];
	assign sx[0]  = dq[NDIV];
	assign srm[0] = '0;
	assign srt[0] = '0;
	assign st[0]  = '{sel: dt[NDIV].sel, sat: dt[NDIV].sat,
	                  tlin: dq[NDIV][Q_W-1:FRAC_BITS]};

	for (genvar i = 0; i < NSQRT; i++) begin : g_sqrt
		gfp_sqrt_cell u_cell (
			.clk, .arst_n, .en,
			.v_i(sv[i]), .x_i(sx[i]), .rem_i(srm[i]), .root_i(srt[i]), .tag_i(st[i]),
			.v_o(sv[i+1]), .x_o(sx[i+1]), .rem_o(srm[i+1]), .root_o(srt[i+1]),
			.tag_o(st[i+1])
		);
	end

	// t select
	logic           v_s4;
	logic [T_W-1:0] t_s4;
	logic [T_W-1:0] t_c;
	tag_t           tag_end;

	assign tag_end = st[NSQRT];

	always_comb begin
		if (tag_end.sel == SEL_ZERO) t_c = '0;
		else if (tag_end.sat) t_c = T_ONE;
		else if (tag_end.sel == SEL_LIN) t_c = T_W'(tag_end.tlin);
		else t_c = T_W'(srt[NSQRT]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= sv[NSQRT];
	end

	always_ff @(posedge clk) begin
		if (en) t_s4 <= t_c;
	end

	// blend, then the output register
	logic  bv;
	rgba_t bpx;

	gfp_blend u_blend (
		.clk, .arst_n, .en,
		.v_i(v_s4), .t_i(t_s4), .c1(start_q), .c2(end_q),
		.v_o(bv), .px_o(bpx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= bv;
	end

	always_ff @(posedge clk) begin
		if (en) rgba <= bpx;
	end

	assign rgba_valid = out_valid_q;

	`GFP_ASSERT_NOW(a_stall_when_full, out_valid_q && rgba_stall, pix_stall)
	`GFP_ASSERT_NOW(a_t_bounded, sv[NSQRT], t_c <= T_ONE)
	`GFP_ASSERT_NEXT(a_sat_gives_one, en && sv[NSQRT] && tag_end.sat && tag_end.sel != SEL_ZERO, t_s4 == T_ONE)
	`GFP_ASSERT_NOW(a_rem_below_div, dv[NDIV], dr[NDIV] < {1'b0, dd[NDIV]})
endmodule
